// ----- rtl/core/crp_speaker_log_likelihood_core_assert.svh -----
// Assertion macros shared by the checker of the speaker log-likelihood core.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef CRP_SPEAKER_LOG_LIKELIHOOD_CORE_ASSERT_SVH
`define CRP_SPEAKER_LOG_LIKELIHOOD_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRP_SLL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRP_SLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/crp_sll_pkg.sv -----
`default_nettype none

package crp_sll_pkg;

    localparam int SPEAKERS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 16;

    localparam int FRAC_BITS = 16;
    localparam int M_W       = 31;
    localparam int SQ_ITERS  = 16;
    localparam int TERM_W    = 32;
    localparam int SUM_W     = 48;

    localparam logic [31:0]       ALPHA_RESET = 32'd65536;
    localparam logic [31:0]       LN2_Q32     = 32'd2977044472;
    localparam logic [TERM_W-1:0] TERM_MIN    = 32'h8000_0000;
    localparam logic [SUM_W-1:0]  SUM_MIN     = 48'h8000_0000_0000;

    // Control of the count memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } mem_ctrl_t;

    // Remainder of an 8-bit id by n, by eight compare-and-subtract steps.
    function automatic logic [7:0] fold_id(input logic [7:0] id, input logic [12:0] n);
        logic [19:0] v;
        logic [19:0] d;
        v = 20'(id);
        for (int k = 7; k >= 0; k--)
        begin
            d = 20'(n) << k;
            if (v >= d)
            begin
                v = v - d;
            end
        end
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crp_sll_log2.sv -----
`default_nettype none

// Shared log2 unit. A binary search normalizes the operand, one step per cycle,
// and then sixteen square-and-compare iterations produce the fraction bits.
module crp_sll_log2 #(
    parameter  int X_W = 41,
    localparam int P_W = $clog2(X_W),
    localparam int K_W = $clog2(P_W)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [X_W-1:0]                      x,
    output logic                                     done,
    output logic [P_W-1:0]                           expo,
    output logic [crp_sll_pkg::FRAC_BITS-1:0]        frac
);

    localparam int IT_W = $clog2(crp_sll_pkg::SQ_ITERS);
    localparam int M_W  = crp_sll_pkg::M_W;
    localparam int F_W  = crp_sll_pkg::FRAC_BITS;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;

    logic [1:0]      state_reg;
    logic [K_W-1:0]  k_reg;
    logic [IT_W-1:0] it_reg;
    logic            done_reg;
    logic [X_W-1:0]  norm_reg;
    logic [P_W-1:0]  expo_reg;
    logic [M_W-1:0]  m_reg;
    logic [F_W-1:0]  frac_reg;

    logic [P_W-1:0]  shamt;
    logic [P_W:0]    keep;
    logic            top_zero;
    logic [X_W-1:0]  norm_sh;
    logic [P_W-1:0]  expo_sh;
    logic [61:0]     sq;
    logic [31:0]     sq_top;

    // The top shamt bits are tested; if they are all zero the word moves up.
    assign shamt    = P_W'(1) << k_reg;
    assign keep     = (P_W + 1)'(X_W) - (P_W + 1)'(shamt);
    assign top_zero = ((norm_reg >> keep) == '0);
    assign norm_sh  = top_zero ? (norm_reg << shamt) : norm_reg;
    assign expo_sh  = top_zero ? (expo_reg - shamt) : expo_reg;

    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign sq_top = sq[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            k_reg     <= '0;
            it_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_NORM;
                        k_reg     <= K_W'(P_W - 1);
                    end
                end
                L_NORM:
                begin
                    if (k_reg == '0)
                    begin
                        state_reg <= L_SQ;
                        it_reg    <= '0;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                L_SQ:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_W'(crp_sll_pkg::SQ_ITERS - 1))
                    begin
                        state_reg <= L_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            norm_reg <= x;
            expo_reg <= P_W'(X_W - 1);
            frac_reg <= '0;
        end
        else if (state_reg == L_NORM)
        begin
            norm_reg <= norm_sh;
            expo_reg <= expo_sh;
            m_reg    <= norm_sh[X_W-1 -: M_W];
        end
        else if (state_reg == L_SQ)
        begin
            if (sq_top[31])
            begin
                frac_reg <= {frac_reg[F_W-2:0], 1'b1};
                m_reg    <= sq_top[31:1];
            end
            else
            begin
                frac_reg <= {frac_reg[F_W-2:0], 1'b0};
                m_reg    <= sq_top[30:0];
            end
        end
    end

    assign done = done_reg;
    assign expo = expo_reg;
    assign frac = frac_reg;

endmodule

`default_nettype wire

// ----- rtl/core/crp_sll_count_mem.sv -----
`default_nettype none

// Per-speaker counts in a single-port memory, with seen flags in flip-flops
// that a document start clears all together.
module crp_sll_count_mem #(
    parameter  int SPEAKERS   = crp_sll_pkg::SPEAKERS_DEF,
    parameter  int COUNT_BITS = crp_sll_pkg::COUNT_BITS_DEF,
    localparam int IDX_W      = $clog2(SPEAKERS)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire crp_sll_pkg::mem_ctrl_t  ctrl,
    input  wire logic [IDX_W-1:0]        addr,
    input  wire logic [COUNT_BITS-1:0]   wr_data,
    output logic [COUNT_BITS-1:0]        rd_data,
    output logic                         rd_seen
);

    logic [COUNT_BITS-1:0] count_mem [SPEAKERS];
    logic [SPEAKERS-1:0]   seen_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            seen_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            seen_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            count_mem[addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= count_mem[addr];
            rd_seen_reg <= seen_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_seen = rd_seen_reg;

endmodule

`default_nettype wire

// ----- rtl/core/crp_speaker_log_likelihood_core.sv -----
// Speaker log-likelihood core (Chinese restaurant process scoring).
// Input channel: in_valid/in_ready carry one item, a speaker_id and a first flag;
// first = 1 starts a new document and clears the counts, the total and the sum.
// Output channel: out_valid/out_ready carry one item per input item: the term
// ln(count / (total + alpha)) in signed Q16.16, with alpha for an unseen speaker's count,
// the saturating running sum log_likelihood and the count_saturated flag.
// Configuration: alpha_we writes alpha_wdata into alpha at the clock edge; write it
// only while the core is idle.
// Sequence: an accepted item passes READ, PREP, LOGN, LOGD, SCALE, ACC, SUM and OUT.
// LOGN and LOGD are two passes through the shared log2 unit (6 normalize steps at the
// default widths, 16 squarings, a handoff); out_valid rises when OUT loads the result.
// An item with a zero numerator or denominator skips both logarithms, from PREP to ACC.
// The core takes no new item while one is at work, since in_ready is high only in IDLE.
// A finished item waits in the output register, so the next input item is taken
// while the receiver stalls; that item then waits for the register to empty.
// Reset sets alpha to 1.0, clears all seen flags, the total and the sum, and
// empties the output register.
`default_nettype none

module crp_speaker_log_likelihood_core #(
    parameter int SPEAKERS   = crp_sll_pkg::SPEAKERS_DEF,
    parameter int COUNT_BITS = crp_sll_pkg::COUNT_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               alpha_we,
    input  wire logic [31:0]        alpha_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         speaker_id,
    input  wire logic               first,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      term,
    output logic signed [47:0]      log_likelihood,
    output logic                    count_saturated
);

    localparam int IDX_W = $clog2(SPEAKERS);
    // Widest operand of the logarithm: total << 16 plus alpha.
    localparam int X_W   = ((COUNT_BITS + 16 > 32) ? COUNT_BITS + 16 : 32) + 1;
    localparam int P_W   = $clog2(X_W);
    localparam int F_W   = crp_sll_pkg::FRAC_BITS;
    localparam int D_W   = P_W + F_W + 1;
    localparam int PR_W  = D_W + 32;
    localparam int T_W   = crp_sll_pkg::TERM_W;
    localparam int S_W   = crp_sll_pkg::SUM_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_LOGN  = 4'd3;
    localparam logic [3:0] S_LOGD  = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // Control state.
    logic [3:0]            state_reg, state_next;
    logic [31:0]           alpha_reg;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [S_W-1:0]        sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;

    // Item data.
    logic [IDX_W-1:0]      id_reg;
    logic [X_W-1:0]        den_reg;
    logic                  zero_reg;
    logic                  sat_reg;
    logic [P_W-1:0]        pn_reg;
    logic [F_W-1:0]        fn_reg;
    logic [D_W-1:0]        diff_reg;
    logic                  neg_reg;
    logic [PR_W-1:0]       prod_reg;
    logic [T_W-1:0]        term_reg;
    logic [T_W-1:0]        out_term_reg;
    logic [S_W-1:0]        out_ll_reg;
    logic                  out_sat_reg;

    logic                    accept;
    logic                    out_load;
    crp_sll_pkg::mem_ctrl_t  mem_ctrl;
    logic [COUNT_BITS-1:0]   mem_cnt;
    logic                    mem_seen;
    logic [COUNT_BITS-1:0]   cnt_wr;
    logic [X_W-1:0]          num;
    logic [X_W-1:0]          den;
    logic                    is_zero;
    logic                    sat_now;
    logic                    log_start;
    logic [X_W-1:0]          log_x;
    logic                    log_done;
    logic [P_W-1:0]          log_expo;
    logic [F_W-1:0]          log_frac;
    logic [D_W-1:0]          mag;
    logic [PR_W:0]           rnd;
    logic [D_W:0]            r_raw;
    logic [32:0]             r_cl;
    logic [T_W-1:0]          term_calc;
    logic [S_W:0]            sum_ext;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Count memory: read in READ, data back in PREP, updated count written in PREP.
    always_comb
    begin
        mem_ctrl.clear = accept && first;
        mem_ctrl.rd_en = (state_reg == S_READ);
        mem_ctrl.wr_en = (state_reg == S_PREP);
    end

    crp_sll_count_mem #(
        .SPEAKERS   (SPEAKERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mem_ctrl),
        .addr    (id_reg),
        .wr_data (cnt_wr),
        .rd_data (mem_cnt),
        .rd_seen (mem_seen)
    );

    // The numerator is the earlier count of a seen speaker, else alpha.
    assign num     = mem_seen ? X_W'({mem_cnt, F_W'(0)}) : X_W'(alpha_reg);
    assign den     = X_W'({total_reg, F_W'(0)}) + X_W'(alpha_reg);
    assign is_zero = (num == '0) || (den == '0);
    assign sat_now = (mem_seen && (mem_cnt == COUNT_MAX)) || (total_reg == COUNT_MAX);
    assign cnt_wr  = !mem_seen ? COUNT_BITS'(1) :
                     ((mem_cnt == COUNT_MAX) ? mem_cnt : mem_cnt + 1'b1);

    // The log2 unit runs first on the numerator, then on the denominator.
    assign log_start = ((state_reg == S_PREP) && !is_zero) ||
                       ((state_reg == S_LOGN) && log_done);
    assign log_x     = (state_reg == S_PREP) ? num : den_reg;

    crp_sll_log2 #(
        .X_W (X_W)
    ) u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .x     (log_x),
        .done  (log_done),
        .expo  (log_expo),
        .frac  (log_frac)
    );

    // Magnitude of the log2 difference times ln2, rounded half away from zero.
    assign mag   = D_W'(0) - diff_reg;
    assign rnd   = (PR_W + 1)'(prod_reg) + (PR_W + 1)'(33'h0_8000_0000);
    assign r_raw = rnd[PR_W:32];
    assign r_cl  = (64'(r_raw) > 64'h8000_0000) ? 33'h0_8000_0000 : 33'(r_raw);

    always_comb
    begin
        if (zero_reg)
        begin
            term_calc = crp_sll_pkg::TERM_MIN;
        end
        else if (neg_reg)
        begin
            term_calc = T_W'(33'd0 - r_cl);
        end
        else
        begin
            // A non-negative difference only comes from a ratio of one or from truncation.
            term_calc = '0;
        end
    end

    // The term is never positive, so the sum can only run off the low end.
    assign sum_ext = {sum_reg[S_W-1], sum_reg} + {{(S_W - T_W + 1){term_reg[T_W-1]}}, term_reg};

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                    if (first)
                    begin
                        total_next = '0;
                        sum_next   = '0;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = is_zero ? S_ACC : S_LOGN;
                if (total_reg != COUNT_MAX)
                begin
                    total_next = total_reg + 1'b1;
                end
            end
            S_LOGN:
            begin
                if (log_done)
                begin
                    state_next = S_LOGD;
                end
            end
            S_LOGD:
            begin
                if (log_done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_OUT;
                if (sum_ext[S_W:S_W-1] == 2'b10)
                begin
                    sum_next = crp_sll_pkg::SUM_MIN;
                end
                else
                begin
                    sum_next = sum_ext[S_W-1:0];
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alpha_reg     <= crp_sll_pkg::ALPHA_RESET;
            total_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (alpha_we)
            begin
                alpha_reg <= alpha_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg <= IDX_W'(crp_sll_pkg::fold_id(speaker_id, 13'(SPEAKERS)));
        end
        if (state_reg == S_PREP)
        begin
            den_reg  <= den;
            zero_reg <= is_zero;
            sat_reg  <= sat_now;
        end
        if ((state_reg == S_LOGN) && log_done)
        begin
            pn_reg <= log_expo;
            fn_reg <= log_frac;
        end
        if ((state_reg == S_LOGD) && log_done)
        begin
            // The -16 bias of both exponents cancels in the difference.
            diff_reg <= {1'b0, pn_reg, fn_reg} - {1'b0, log_expo, log_frac};
        end
        if (state_reg == S_SCALE)
        begin
            neg_reg  <= diff_reg[D_W-1];
            prod_reg <= PR_W'(mag) * PR_W'(crp_sll_pkg::LN2_Q32);
        end
        if (state_reg == S_ACC)
        begin
            term_reg <= term_calc;
        end
        if (out_load)
        begin
            out_term_reg <= term_reg;
            out_ll_reg   <= sum_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign term            = $signed(out_term_reg);
    assign log_likelihood  = $signed(out_ll_reg);
    assign count_saturated = out_sat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/crp_sll_checker.sv -----
`default_nettype none

`include "crp_speaker_log_likelihood_core_assert.svh"

// Port-level checks of the speaker log-likelihood core.
module crp_sll_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] term,
    input wire logic [47:0] log_likelihood
);

    `CRP_SLL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(term) && $stable(log_likelihood), "result item changed while stalled")
    `CRP_SLL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "core ready again right after taking an item")
    `CRP_SLL_ASSERT_NOW(a_term_nonpos, out_valid, term[31] || (term == 32'd0), "positive log probability")
    `CRP_SLL_ASSERT_NOW(a_sum_nonpos, out_valid, log_likelihood[47] || (log_likelihood == 48'd0), "positive running log-likelihood")

endmodule

bind crp_speaker_log_likelihood_core crp_sll_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .term           (term),
    .log_likelihood (log_likelihood)
);

`default_nettype wire
